[rtl/can_frame_to_slcan_ascii_macros.svh]
// Assertion helpers used by the file that checks this block.
`ifndef CAN_FRAME_TO_SLCAN_ASCII_MACROS_SVH
`define CAN_FRAME_TO_SLCAN_ASCII_MACROS_SVH

// The consequent must hold in the same cycle as the trigger.
`define CFSA_ASSERT_SAME(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the trigger.
`define CFSA_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cfsa_pkg.sv]
package cfsa_pkg;

    localparam int MAX_DATA_BYTES_DEF = 8;

    localparam int ID_W      = 29;
    localparam int STD_ID_W  = 11;
    localparam int LEN_W     = 4;
    localparam int PAYLOAD_W = 64;
    localparam int STAMP_W   = 16;
    localparam int CHAR_W    = 8;
    localparam int NIB_W     = 4;
    localparam int BYTE_W    = 8;
    localparam int ID_SR_W   = 32;

    localparam int EXT_ID_DIGITS = 8;
    localparam int STD_ID_DIGITS = 3;
    localparam int STAMP_DIGITS  = 4;

    // Line sequencer phases.
    localparam int PH_W = 3;
    localparam logic [PH_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PH_W-1:0] PH_LETTER = 3'd1;
    localparam logic [PH_W-1:0] PH_ID     = 3'd2;
    localparam logic [PH_W-1:0] PH_LEN    = 3'd3;
    localparam logic [PH_W-1:0] PH_DATA   = 3'd4;
    localparam logic [PH_W-1:0] PH_STAMP  = 3'd5;
    localparam logic [PH_W-1:0] PH_CR     = 3'd6;

    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_STD     = 8'h74; // t
    localparam logic [CHAR_W-1:0] CH_EXT     = 8'h54; // T
    localparam logic [CHAR_W-1:0] CH_STD_RTR = 8'h72; // r
    localparam logic [CHAR_W-1:0] CH_EXT_RTR = 8'h52; // R

    // Register file.
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_LSB = 2;
    localparam logic REG_STAMP_CH0 = 1'b0;
    localparam logic REG_STAMP_CH1 = 1'b1;

    typedef struct packed {
        logic            load;
        logic            ext;
        logic            step;
        logic [PH_W-1:0] phase;
    } dig_ctrl_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [NIB_W-1:0] v);
        logic [CHAR_W-1:0] wide;
        wide = {4'h0, v};
        if (v < 4'd10)
        begin
            return 8'h30 + wide;
        end
        return 8'h37 + wide;
    endfunction

endpackage

[rtl/cfsa_frame_if.sv]
interface cfsa_frame_if;
    logic                           valid;
    logic                           ready;
    logic [cfsa_pkg::ID_W-1:0]      frame_id;
    logic                           extended;
    logic                           remote;
    logic [cfsa_pkg::LEN_W-1:0]     length;
    logic [cfsa_pkg::PAYLOAD_W-1:0] payload;
    logic [cfsa_pkg::STAMP_W-1:0]   stamp;
    logic                           source_channel;

    modport source (
        output valid, frame_id, extended, remote, length, payload, stamp, source_channel,
        input  ready
    );

    modport sink (
        input  valid, frame_id, extended, remote, length, payload, stamp, source_channel,
        output ready
    );
endinterface

[rtl/cfsa_char_if.sv]
interface cfsa_char_if;
    logic                        valid;
    logic                        ready;
    logic [cfsa_pkg::CHAR_W-1:0] ascii_char;
    logic                        last_char;

    modport source (
        output valid, ascii_char, last_char,
        input  ready
    );

    modport sink (
        input  valid, ascii_char, last_char,
        output ready
    );
endinterface

[rtl/cfsa_cfg.sv]
module cfsa_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cfsa_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cfsa_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cfsa_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [1:0]                          stamp_en
);

    logic [1:0] en_reg;
    logic [1:0] en_next;
    logic       idx;
    logic       wr;

    assign idx    = paddr[cfsa_pkg::REG_IDX_LSB];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        en_next = en_reg;
        if (wr)
        begin
            case (idx)
                cfsa_pkg::REG_STAMP_CH0: en_next[0] = pwdata[0];
                cfsa_pkg::REG_STAMP_CH1: en_next[1] = pwdata[0];
                default: en_next = en_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg <= 2'b00;
        end
        else
        begin
            en_reg <= en_next;
        end
    end

    assign prdata   = {{(cfsa_pkg::APB_DATA_W-1){1'b0}}, en_reg[idx]};
    assign stamp_en = en_reg;

endmodule

[rtl/cfsa_digits.sv]
module cfsa_digits #(
    parameter int MAX_DATA_BYTES = cfsa_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic                                clk,
    input  cfsa_pkg::dig_ctrl_t                 ctrl,
    input  logic [cfsa_pkg::ID_W-1:0]           frame_id,
    input  logic [cfsa_pkg::PAYLOAD_W-1:0]      payload,
    input  logic [cfsa_pkg::STAMP_W-1:0]        stamp,
    output logic [cfsa_pkg::NIB_W-1:0]          nib
);

    localparam int DATA_W = cfsa_pkg::BYTE_W * MAX_DATA_BYTES;
    localparam int NW     = cfsa_pkg::NIB_W;

    logic [cfsa_pkg::ID_SR_W-1:0] id_reg;
    logic [cfsa_pkg::ID_SR_W-1:0] id_next;
    logic [DATA_W-1:0]            data_reg;
    logic [DATA_W-1:0]            data_next;
    logic [cfsa_pkg::STAMP_W-1:0] stamp_reg;
    logic [cfsa_pkg::STAMP_W-1:0] stamp_next;

    // Identifiers are left aligned so the leading digit always sits at the top.
    // Data bytes are loaded nibble swapped, so the low end yields the high digit first.
    always_comb
    begin
        id_next    = id_reg;
        data_next  = data_reg;
        stamp_next = stamp_reg;
        if (ctrl.load)
        begin
            if (ctrl.ext)
            begin
                id_next = {3'b000, frame_id};
            end
            else
            begin
                id_next = {1'b0, frame_id[cfsa_pkg::STD_ID_W-1:0], 20'h00000};
            end
            for (int i = 0; i < MAX_DATA_BYTES; i++)
            begin
                data_next[cfsa_pkg::BYTE_W*i +: cfsa_pkg::BYTE_W] =
                    {payload[cfsa_pkg::BYTE_W*i +: NW], payload[cfsa_pkg::BYTE_W*i + NW +: NW]};
            end
            stamp_next = stamp;
        end
        else if (ctrl.step)
        begin
            case (ctrl.phase)
                cfsa_pkg::PH_ID:    id_next    = id_reg << NW;
                cfsa_pkg::PH_DATA:  data_next  = data_reg >> NW;
                cfsa_pkg::PH_STAMP: stamp_next = stamp_reg << NW;
                default:            id_next    = id_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        data_reg  <= data_next;
        stamp_reg <= stamp_next;
    end

    always_comb
    begin
        case (ctrl.phase)
            cfsa_pkg::PH_ID:    nib = id_reg[cfsa_pkg::ID_SR_W-1 -: NW];
            cfsa_pkg::PH_DATA:  nib = data_reg[NW-1:0];
            cfsa_pkg::PH_STAMP: nib = stamp_reg[cfsa_pkg::STAMP_W-1 -: NW];
            default:            nib = '0;
        endcase
    end

endmodule

[rtl/cfsa_seq.sv]
module cfsa_seq #(
    parameter int MAX_DATA_BYTES = cfsa_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                extended,
    input  logic                                remote,
    input  logic [cfsa_pkg::LEN_W-1:0]          length,
    input  logic                                source_channel,
    input  logic [1:0]                          stamp_en,
    input  logic [cfsa_pkg::NIB_W-1:0]          nib,
    output cfsa_pkg::dig_ctrl_t                 ctrl,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [cfsa_pkg::CHAR_W-1:0]         ascii_char,
    output logic                                last_char
);

    localparam int CNT_W = ($clog2(2 * MAX_DATA_BYTES) > 3) ? $clog2(2 * MAX_DATA_BYTES) : 3;
    localparam logic [cfsa_pkg::LEN_W-1:0] MAX_LEN = cfsa_pkg::LEN_W'(MAX_DATA_BYTES);

    logic [cfsa_pkg::PH_W-1:0]   state_reg;
    logic [cfsa_pkg::PH_W-1:0]   state_next;
    logic                        ovalid_reg;
    logic                        ovalid_next;
    logic [CNT_W-1:0]            cnt_reg;
    logic [CNT_W-1:0]            cnt_next;
    logic [cfsa_pkg::CHAR_W-1:0] char_reg;
    logic [cfsa_pkg::CHAR_W-1:0] char_next;
    logic                        last_reg;
    logic                        last_next;
    logic [cfsa_pkg::LEN_W-1:0]  len_reg;
    logic [cfsa_pkg::CHAR_W-1:0] letter_reg;
    logic                        ext_reg;
    logic                        stamp_reg;

    logic accept;
    logic len_ok;
    logic busy;
    logic advance;

    assign in_ready = (state_reg == cfsa_pkg::PH_IDLE);
    assign accept   = in_valid && in_ready;
    assign len_ok   = (length <= MAX_LEN);
    assign busy     = (state_reg != cfsa_pkg::PH_IDLE);
    // A new character may be loaded whenever the output register is empty or draining.
    assign advance  = !ovalid_reg || out_ready;

    assign ctrl.load  = accept && len_ok;
    assign ctrl.ext   = extended;
    assign ctrl.step  = advance && busy;
    assign ctrl.phase = state_reg;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        ovalid_next = ovalid_reg && !out_ready;
        if (advance && busy)
        begin
            ovalid_next = 1'b1;
            last_next   = 1'b0;
        end
        case (state_reg)
            cfsa_pkg::PH_IDLE:
            begin
                if (accept && len_ok)
                begin
                    state_next = cfsa_pkg::PH_LETTER;
                end
            end
            cfsa_pkg::PH_LETTER:
            begin
                if (advance)
                begin
                    char_next  = letter_reg;
                    cnt_next   = ext_reg ? CNT_W'(cfsa_pkg::EXT_ID_DIGITS - 1)
                                         : CNT_W'(cfsa_pkg::STD_ID_DIGITS - 1);
                    state_next = cfsa_pkg::PH_ID;
                end
            end
            cfsa_pkg::PH_ID:
            begin
                if (advance)
                begin
                    char_next = cfsa_pkg::hex_char(nib);
                    cnt_next  = cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_next = cfsa_pkg::PH_LEN;
                    end
                end
            end
            cfsa_pkg::PH_LEN:
            begin
                if (advance)
                begin
                    char_next = cfsa_pkg::hex_char(len_reg);
                    if (len_reg != '0)
                    begin
                        cnt_next   = CNT_W'({len_reg, 1'b0} - 5'd1);
                        state_next = cfsa_pkg::PH_DATA;
                    end
                    else if (stamp_reg)
                    begin
                        cnt_next   = CNT_W'(cfsa_pkg::STAMP_DIGITS - 1);
                        state_next = cfsa_pkg::PH_STAMP;
                    end
                    else
                    begin
                        state_next = cfsa_pkg::PH_CR;
                    end
                end
            end
            cfsa_pkg::PH_DATA:
            begin
                if (advance)
                begin
                    char_next = cfsa_pkg::hex_char(nib);
                    cnt_next  = cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        if (stamp_reg)
                        begin
                            cnt_next   = CNT_W'(cfsa_pkg::STAMP_DIGITS - 1);
                            state_next = cfsa_pkg::PH_STAMP;
                        end
                        else
                        begin
                            state_next = cfsa_pkg::PH_CR;
                        end
                    end
                end
            end
            cfsa_pkg::PH_STAMP:
            begin
                if (advance)
                begin
                    char_next = cfsa_pkg::hex_char(nib);
                    cnt_next  = cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_next = cfsa_pkg::PH_CR;
                    end
                end
            end
            cfsa_pkg::PH_CR:
            begin
                if (advance)
                begin
                    char_next  = cfsa_pkg::CH_CR;
                    last_next  = 1'b1;
                    state_next = cfsa_pkg::PH_IDLE;
                end
            end
            default:
            begin
                state_next = cfsa_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= cfsa_pkg::PH_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        char_reg <= char_next;
        last_reg <= last_next;
        if (accept)
        begin
            len_reg   <= length;
            ext_reg   <= extended;
            stamp_reg <= source_channel ? stamp_en[1] : stamp_en[0];
            if (extended)
            begin
                letter_reg <= remote ? cfsa_pkg::CH_EXT_RTR : cfsa_pkg::CH_EXT;
            end
            else
            begin
                letter_reg <= remote ? cfsa_pkg::CH_STD_RTR : cfsa_pkg::CH_STD;
            end
        end
    end

    assign out_valid  = ovalid_reg;
    assign ascii_char = char_reg;
    assign last_char  = last_reg;

endmodule

[rtl/can_frame_to_slcan_ascii.sv]
// Turns each received CAN frame into its SLCAN text line, one character per beat on
// the text channel, the closing carriage return marked by last_char. The fields are
// taken apart one hex digit per cycle, while the text sink accepts, through nibble
// shift registers, and the single output character register sets the pace. A line
// has 1 + (3 or 8) + 1 + 2*length + (0 or 4) + 1 characters, from 6 up to 31. The
// next frame is taken as soon as the carriage return sits in the output register. A
// frame whose length exceeds MAX_DATA_BYTES is taken and produces nothing. Timestamps
// are appended per source channel under the two enable registers at byte addresses 0
// and 4; the user is to write these only between lines, the block does not enforce it.
`include "can_frame_to_slcan_ascii_macros.svh"

module can_frame_to_slcan_ascii #(
    parameter int MAX_DATA_BYTES = cfsa_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    cfsa_frame_if.sink                          frame,
    cfsa_char_if.source                         text,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cfsa_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cfsa_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cfsa_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic [1:0]                  stamp_en;
    logic [cfsa_pkg::NIB_W-1:0]  nib;
    cfsa_pkg::dig_ctrl_t         ctrl;

    cfsa_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .stamp_en (stamp_en)
    );

    cfsa_digits #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_digits (
        .clk      (clk),
        .ctrl     (ctrl),
        .frame_id (frame.frame_id),
        .payload  (frame.payload),
        .stamp    (frame.stamp),
        .nib      (nib)
    );

    cfsa_seq #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (frame.valid),
        .in_ready       (frame.ready),
        .extended       (frame.extended),
        .remote         (frame.remote),
        .length         (frame.length),
        .source_channel (frame.source_channel),
        .stamp_en       (stamp_en),
        .nib            (nib),
        .ctrl           (ctrl),
        .out_valid      (text.valid),
        .out_ready      (text.ready),
        .ascii_char     (text.ascii_char),
        .last_char      (text.last_char)
    );

    `CFSA_ASSERT_SAME(a_last_is_cr, text.valid && text.last_char, text.ascii_char == cfsa_pkg::CH_CR, "line end is not a carriage return")
    `CFSA_ASSERT_NEXT(a_drop_long, frame.valid && frame.ready && (frame.length > cfsa_pkg::LEN_W'(MAX_DATA_BYTES)), frame.ready, "oversized frame started a line")
    `CFSA_ASSERT_NEXT(a_start_line, frame.valid && frame.ready && (frame.length <= cfsa_pkg::LEN_W'(MAX_DATA_BYTES)), !frame.ready, "valid frame did not start a line")
    `CFSA_ASSERT_NEXT(a_line_unbroken, text.valid && text.ready && !text.last_char, text.valid, "gap inside a line")

endmodule
